// ----- hdl/stf_pkg.sv -----
// Shared types and constants for the subscriber table fanout block.
`default_nettype none
package stf_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W       = 6;
    localparam int IP_W          = 32;
    localparam int PORT_W        = 16;
    localparam int MASK_W        = 32;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_INSERTED = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_FULL     = 3'd4,
        ST_DEST     = 3'd5,
        ST_NONE     = 3'd6
    } status_t;

    typedef enum logic {
        CMD_EDIT   = 1'b0,
        CMD_FANOUT = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } seq_state_t;

    // One slot as seen at the table's read port.
    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } slot_rd_t;

    // Write request from the sequencer to the table.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic              valid;
        logic [MASK_W-1:0] mask;
        logic              key_en;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
    } slot_wr_t;

    typedef struct packed {
        status_t            status;
        logic [ENTRY_W-1:0] entry_index;
        logic [IP_W-1:0]    dest_ip;
        logic [PORT_W-1:0]  dest_port;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/stf_table.sv -----
// Subscriber slot storage: valid bits, masks, addresses and ports.
`default_nettype none
module stf_table (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  [stf_pkg::IDX_W-1:0] rd_idx,
    output stf_pkg::slot_rd_t        rd,
    input  stf_pkg::slot_wr_t        wr
);
    import stf_pkg::*;

    logic              valid_reg [TABLE_ENTRIES];
    logic [MASK_W-1:0] mask_reg  [TABLE_ENTRIES];
    logic [IP_W-1:0]   ip_reg    [TABLE_ENTRIES];
    logic [PORT_W-1:0] port_reg  [TABLE_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                mask_reg[i]  <= '0;
            end
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= wr.valid;
            mask_reg[wr.idx]  <= wr.mask;
        end
    end

    // Address and port need no reset: they are only looked at in a valid slot.
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.key_en)
        begin
            ip_reg[wr.idx]   <= wr.ip;
            port_reg[wr.idx] <= wr.port;
        end
    end

    always_comb
    begin
        rd.valid = valid_reg[rd_idx];
        rd.mask  = mask_reg[rd_idx];
        rd.ip    = ip_reg[rd_idx];
        rd.port  = port_reg[rd_idx];
    end

endmodule
`default_nettype wire

// ----- hdl/stf_seq.sv -----
// Sequencer that walks the table one slot a cycle, unless held by a busy output, through a shared compare unit.
`default_nettype none
module stf_seq (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  stf_pkg::cmd_t              in_cmd,
    input  wire  [stf_pkg::IP_W-1:0]   in_ip,
    input  wire  [stf_pkg::PORT_W-1:0] in_port,
    input  wire  [stf_pkg::MASK_W-1:0] in_mask,
    input  wire                        in_payload,
    output logic [stf_pkg::IDX_W-1:0]  rd_idx,
    input  stf_pkg::slot_rd_t          rd,
    output stf_pkg::slot_wr_t          wr,
    output logic                       res_valid,
    output stf_pkg::result_t           res,
    input  wire                        res_ready
);
    import stf_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              payload_reg, payload_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [IP_W-1:0]   pend_ip_reg, pend_ip_next;
    logic [PORT_W-1:0] pend_port_reg, pend_port_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // The shared compare unit: one slot against the held item each cycle.
    logic key_hit, mask_hit, dest_hit, at_end, negative;

    assign negative = mask_reg[MASK_W-1];
    assign key_hit  = rd.valid && (rd.ip == ip_reg) && (rd.port == port_reg);
    assign mask_hit = rd.valid && ((rd.mask & mask_reg) != '0);
    assign dest_hit = payload_reg && mask_hit && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign at_end   = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign rd_idx   = idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        ip_next         = ip_reg;
        port_next       = port_reg;
        mask_next       = mask_reg;
        payload_next    = payload_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_ip_next    = pend_ip_reg;
        pend_port_next  = pend_port_reg;
        cnt_next        = cnt_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        res             = '{status: ST_NONE, entry_index: '0, dest_ip: '0,
                            dest_port: '0, last: 1'b1};
        wr              = '{en: 1'b0, idx: '0, valid: 1'b0, mask: '0,
                            key_en: 1'b0, ip: '0, port: '0};

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next        = in_cmd;
                    ip_next         = in_ip;
                    port_next       = in_port;
                    mask_next       = in_mask;
                    payload_next    = in_payload;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (cmd_reg == CMD_EDIT)
                begin
                    if (key_hit && !found_reg)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = idx_reg;
                    end
                    if (!rd.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (at_end)
                    begin
                        state_next = S_FINISH;
                    end
                end
                // A destination is held back one step so that the final one
                // can carry last; the scan waits while the output is busy and a new one is found.
                else if (!(dest_hit && pend_valid_reg && !res_ready))
                begin
                    if (dest_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid = 1'b1;
                            res = '{status: ST_DEST,
                                    entry_index: ENTRY_W'(pend_idx_reg),
                                    dest_ip: pend_ip_reg,
                                    dest_port: pend_port_reg, last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                        pend_ip_next    = rd.ip;
                        pend_port_next  = rd.port;
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (at_end)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (cmd_reg == CMD_EDIT)
                begin
                    if (found_reg)
                    begin
                        res.status      = negative ? ST_REMOVED : ST_UPDATED;
                        res.entry_index = ENTRY_W'(hit_idx_reg);
                        wr.idx          = hit_idx_reg;
                        wr.valid        = !negative;
                        wr.mask         = negative ? '0 : mask_reg;
                        wr.en           = res_ready;
                    end
                    else if (negative)
                    begin
                        res.status = ST_UNKNOWN;
                    end
                    else if (free_found_reg)
                    begin
                        res.status      = ST_INSERTED;
                        res.entry_index = ENTRY_W'(free_idx_reg);
                        wr.idx          = free_idx_reg;
                        wr.valid        = 1'b1;
                        wr.mask         = mask_reg;
                        wr.key_en       = 1'b1;
                        wr.ip           = ip_reg;
                        wr.port         = port_reg;
                        wr.en           = res_ready;
                    end
                    else
                    begin
                        res.status = ST_FULL;
                    end
                end
                else if (pend_valid_reg)
                begin
                    res = '{status: ST_DEST, entry_index: ENTRY_W'(pend_idx_reg),
                            dest_ip: pend_ip_reg, dest_port: pend_port_reg,
                            last: 1'b1};
                end
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ip_reg        <= ip_next;
        port_reg      <= port_next;
        mask_reg      <= mask_next;
        payload_reg   <= payload_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_idx_reg  <= pend_idx_next;
        pend_ip_reg   <= pend_ip_next;
        pend_port_reg <= pend_port_next;
    end

endmodule
`default_nettype wire

// ----- hdl/subscriber_table_fanout_top.sv -----
// Top level of the subscriber table fanout block with its output register.
//
// Channel  Dir  Fields
// s_*      in   tdata: client_ip[31:0], client_port[47:32], mask_value[79:48];
//               tuser: cmd[0], has_payload[1]
// m_*      out  tdata: entry_index[5:0], dest_ip[37:6], dest_port[53:38];
//               tuser: status[2:0]; tlast: last
//
// Each item is taken in the idle state; the sequencer then reads the table slot
// by slot through its single compare unit, and a finishing state completes the
// edit or the final result. No new item is taken until the last one is finished.
// A stall at the output holds the scan whenever a further destination is found while one is held.
// Reset clears the valid bits and masks at once; no clearing pass is needed.
`default_nettype none
module subscriber_table_fanout_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [79:0] s_tdata,  // client_ip, client_port, mask_value
    input  wire  [1:0]  s_tuser,  // cmd, has_payload
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,  // entry_index, dest_ip, dest_port, zero fill
    output logic [2:0]  m_tuser,  // status
    output logic        m_tlast
);
    import stf_pkg::*;

    slot_rd_t         rd;
    slot_wr_t         wr;
    logic [IDX_W-1:0] rd_idx;
    logic             res_valid;
    result_t          res;
    logic             res_ready;
    logic             oreg_valid_reg, oreg_valid_next;
    result_t          oreg_reg, oreg_next;

    stf_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd     (rd),
        .wr     (wr)
    );

    stf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd_t'(s_tuser[0])),
        .in_ip      (s_tdata[31:0]),
        .in_port    (s_tdata[47:32]),
        .in_mask    (s_tdata[79:48]),
        .in_payload (s_tuser[1]),
        .rd_idx     (rd_idx),
        .rd         (rd),
        .wr         (wr),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // The output register takes a new item whenever it is empty or being drained.
    assign res_ready = !oreg_valid_reg || m_tready;

    always_comb
    begin
        oreg_valid_next = oreg_valid_reg;
        oreg_next       = oreg_reg;
        if (res_ready)
        begin
            oreg_valid_next = res_valid;
            oreg_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oreg_valid_reg <= 1'b0;
        end
        else
        begin
            oreg_valid_reg <= oreg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oreg_reg <= oreg_next;
    end

    assign m_tvalid = oreg_valid_reg;
    assign m_tdata  = {2'b00, oreg_reg.dest_port, oreg_reg.dest_ip, oreg_reg.entry_index};
    assign m_tuser  = oreg_reg.status;
    assign m_tlast  = oreg_reg.last;

endmodule
`default_nettype wire
